>>> design/bm25ts_pkg.sv
// Shared types, constants and register codes for the BM25 term score core.
`timescale 1ns / 1ps

package bm25ts_pkg;

    localparam int SCORE_W      = 24;
    localparam int FREQ_W       = 16;
    localparam int PROD_W       = FREQ_W + SCORE_W;   // raw scaled-frequency product
    localparam int LEN_PROD_W   = 2 * SCORE_W;        // slope * doc_length
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W    = 3;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NUM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_CONST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SLOPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_ENABLE = 3'd5;

    // merge codes
    localparam logic [1:0] MERGE_REPLACE = 2'd0;
    localparam logic [1:0] MERGE_SUM     = 2'd1;
    localparam logic [1:0] MERGE_MAX     = 2'd2;

    // reset values
    localparam logic [SCORE_W-1:0] WEIGHT_NUM_RST   = 24'd65536;
    localparam logic [SCORE_W-1:0] LENGTH_CONST_RST = 24'd78643;
    localparam logic [SCORE_W-1:0] LENGTH_SLOPE_RST = 24'd0;
    localparam logic               LENGTH_MODE_RST  = 1'b1;
    localparam logic [1:0]         MERGE_MODE_RST   = MERGE_REPLACE;
    localparam logic               SCALE_ENABLE_RST = 1'b0;

    typedef struct packed {
        logic [FREQ_W-1:0]  term_freq;
        logic [SCORE_W-1:0] freq_scale;
        logic [SCORE_W-1:0] doc_length;
        logic [SCORE_W-1:0] prior_score;
        logic               block_last;
    } item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               block_last_out;
    } result_t;

    typedef struct packed {
        logic [SCORE_W-1:0] weight_num;
        logic [SCORE_W-1:0] length_const;
        logic [SCORE_W-1:0] length_slope;
        logic               length_mode;
        logic [1:0]         merge_mode;
        logic               scale_enable;
    } cfg_t;

    // data that rides along the divider chain untouched
    typedef struct packed {
        logic [SCORE_W-1:0] prior_score;
        logic               block_last;
        logic               den_zero;
    } side_t;

endpackage

>>> design/bm25_term_score_core.sv
// Top level of the BM25 / BM15 per-posting term score core.
`timescale 1ns / 1ps

// Takes one posting per cycle (busy is always low) and passes each one
// through front stages for scaling, length factor and multiply, a row of
// 24 divider cells that each retire one quotient bit, and a merge
// register. The result appears on result for the single cycle
// in which done is high; there is no way to hold it, so the receiver must
// take it then. Registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no posting is in flight.

module bm25_term_score_core #(
    parameter int FRAC_BITS = bm25ts_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  bm25ts_pkg::item_t                    item,
    output logic                                 done,
    output bm25ts_pkg::result_t                  result,
    input  logic                                 cfg_we,
    input  logic [bm25ts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bm25ts_pkg::SCORE_W-1:0]       cfg_data
);
    localparam int TF_W  = bm25ts_pkg::FREQ_W + FRAC_BITS;
    localparam int DEN_W = TF_W + 1;
    localparam int NUM_W = bm25ts_pkg::SCORE_W + TF_W;
    localparam int SW    = bm25ts_pkg::SCORE_W;
    localparam int NCELL = bm25ts_pkg::SCORE_W;

    bm25ts_pkg::cfg_t    cfg_reg, cfg_next;

    logic                front_valid;
    logic [NUM_W-1:0]    front_num;
    logic [DEN_W-1:0]    front_den;
    bm25ts_pkg::side_t   front_side;

    logic                chain_valid [0:NCELL];
    logic [DEN_W-1:0]    chain_rem   [0:NCELL];
    logic [DEN_W-1:0]    chain_den   [0:NCELL];
    logic [SW-1:0]       chain_num   [0:NCELL];
    logic [SW-1:0]       chain_quo   [0:NCELL];
    bm25ts_pkg::side_t   chain_side  [0:NCELL];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bm25ts_pkg::REG_WEIGHT_NUM:   cfg_next.weight_num   = cfg_data;
                bm25ts_pkg::REG_LENGTH_CONST: cfg_next.length_const = cfg_data;
                bm25ts_pkg::REG_LENGTH_SLOPE: cfg_next.length_slope = cfg_data;
                bm25ts_pkg::REG_LENGTH_MODE:  cfg_next.length_mode  = cfg_data[0];
                bm25ts_pkg::REG_MERGE_MODE:   cfg_next.merge_mode   = cfg_data[1:0];
                bm25ts_pkg::REG_SCALE_ENABLE: cfg_next.scale_enable = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_num   <= bm25ts_pkg::WEIGHT_NUM_RST;
            cfg_reg.length_const <= bm25ts_pkg::LENGTH_CONST_RST;
            cfg_reg.length_slope <= bm25ts_pkg::LENGTH_SLOPE_RST;
            cfg_reg.length_mode  <= bm25ts_pkg::LENGTH_MODE_RST;
            cfg_reg.merge_mode   <= bm25ts_pkg::MERGE_MODE_RST;
            cfg_reg.scale_enable <= bm25ts_pkg::SCALE_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy = 1'b0;

    bm25ts_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .item      (item),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_num   (front_num),
        .out_den   (front_den),
        .out_side  (front_side)
    );

    // quotient fits SCORE_W bits, so the upper dividend bits seed the remainder
    assign chain_valid[0] = front_valid;
    assign chain_rem[0]   = DEN_W'(front_num[NUM_W-1:SW]);
    assign chain_den[0]   = front_den;
    assign chain_num[0]   = front_num[SW-1:0];
    assign chain_quo[0]   = '0;
    assign chain_side[0]  = front_side;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        bm25ts_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_rem    (chain_rem[i]),
            .in_den    (chain_den[i]),
            .in_num    (chain_num[i]),
            .in_quo    (chain_quo[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_rem   (chain_rem[i+1]),
            .out_den   (chain_den[i+1]),
            .out_num   (chain_num[i+1]),
            .out_quo   (chain_quo[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    bm25ts_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[NCELL]),
        .in_quo     (chain_quo[NCELL]),
        .in_side    (chain_side[NCELL]),
        .merge_mode (cfg_reg.merge_mode),
        .done       (done),
        .result     (result)
    );

endmodule

>>> design/bm25ts_front.sv
// Front pipeline: frequency scaling, length factor, dividend and divisor.
`timescale 1ns / 1ps

module bm25ts_front #(
    parameter int FRAC_BITS = bm25ts_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  bm25ts_pkg::item_t                 item,
    input  bm25ts_pkg::cfg_t                  cfg,
    output logic                              out_valid,
    output logic [bm25ts_pkg::SCORE_W+16+FRAC_BITS-1:0] out_num,
    output logic [16+FRAC_BITS:0]             out_den,
    output bm25ts_pkg::side_t                 out_side
);
    localparam int TF_W  = bm25ts_pkg::FREQ_W + FRAC_BITS;
    localparam int DEN_W = TF_W + 1;
    localparam int NUM_W = bm25ts_pkg::SCORE_W + TF_W;
    localparam int PW    = bm25ts_pkg::PROD_W;
    localparam int LW    = bm25ts_pkg::LEN_PROD_W;
    localparam int SW    = bm25ts_pkg::SCORE_W;

    // stage 1: products
    logic                      v1_reg, v1_next;
    logic [PW-1:0]             prod1_reg, prod1_next;
    logic [LW-1:0]             len1_reg, len1_next;
    logic [SW-1:0]             prior1_reg;
    logic                      last1_reg;
    // stage 2: saturated tf and c1
    logic                      v2_reg;
    logic [TF_W-1:0]           tf2_reg, tf2_next;
    logic [SW-1:0]             c12_reg, c12_next;
    logic [SW-1:0]             prior2_reg;
    logic                      last2_reg;
    // stage 3: dividend and divisor
    logic                      v3_reg;
    logic [NUM_W-1:0]          num3_reg, num3_next;
    logic [DEN_W-1:0]          den3_reg, den3_next;
    logic                      zero3_reg, zero3_next;
    logic [SW-1:0]             prior3_reg;
    logic                      last3_reg;

    logic [LW:0]               len_sum;

    always_comb
    begin
        v1_next = in_valid;
        if (cfg.scale_enable)
            prod1_next = PW'(item.term_freq) * PW'(item.freq_scale);
        else
            prod1_next = PW'({item.term_freq, {FRAC_BITS{1'b0}}});
        len1_next = LW'(cfg.length_slope) * LW'(item.doc_length);
    end

    always_comb
    begin
        if (prod1_reg > PW'({TF_W{1'b1}}))
            tf2_next = {TF_W{1'b1}};
        else
            tf2_next = prod1_reg[TF_W-1:0];
        len_sum = (LW+1)'(len1_reg) + (LW+1)'(cfg.length_const);
        if (!cfg.length_mode)
            c12_next = cfg.length_const;
        else if (len_sum > (LW+1)'(bm25ts_pkg::SCORE_MAX))
            c12_next = bm25ts_pkg::SCORE_MAX;
        else
            c12_next = len_sum[SW-1:0];
    end

    always_comb
    begin
        num3_next  = NUM_W'(cfg.weight_num) * NUM_W'(tf2_reg);
        den3_next  = DEN_W'(c12_reg) + DEN_W'(tf2_reg);
        zero3_next = (c12_reg == '0) && (tf2_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg  <= prod1_next;
        len1_reg   <= len1_next;
        prior1_reg <= item.prior_score;
        last1_reg  <= item.block_last;
        tf2_reg    <= tf2_next;
        c12_reg    <= c12_next;
        prior2_reg <= prior1_reg;
        last2_reg  <= last1_reg;
        num3_reg   <= num3_next;
        den3_reg   <= den3_next;
        zero3_reg  <= zero3_next;
        prior3_reg <= prior2_reg;
        last3_reg  <= last2_reg;
    end

    assign out_valid            = v3_reg;
    assign out_num              = num3_reg;
    assign out_den              = den3_reg;
    assign out_side.prior_score = prior3_reg;
    assign out_side.block_last  = last3_reg;
    assign out_side.den_zero    = zero3_reg;

endmodule

>>> design/bm25ts_div_cell.sv
// One restoring-division cell: retires one quotient bit per item.
`timescale 1ns / 1ps

module bm25ts_div_cell #(
    parameter int FRAC_BITS = bm25ts_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [16+FRAC_BITS:0]             in_rem,
    input  logic [16+FRAC_BITS:0]             in_den,
    input  logic [bm25ts_pkg::SCORE_W-1:0]    in_num,
    input  logic [bm25ts_pkg::SCORE_W-1:0]    in_quo,
    input  bm25ts_pkg::side_t                 in_side,
    output logic                              out_valid,
    output logic [16+FRAC_BITS:0]             out_rem,
    output logic [16+FRAC_BITS:0]             out_den,
    output logic [bm25ts_pkg::SCORE_W-1:0]    out_num,
    output logic [bm25ts_pkg::SCORE_W-1:0]    out_quo,
    output bm25ts_pkg::side_t                 out_side
);
    localparam int DEN_W = bm25ts_pkg::FREQ_W + FRAC_BITS + 1;
    localparam int SW    = bm25ts_pkg::SCORE_W;

    logic                 valid_reg;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg;
    logic [SW-1:0]        num_reg, num_next;
    logic [SW-1:0]        quo_reg, quo_next;
    bm25ts_pkg::side_t    side_reg;

    logic [DEN_W:0]       trial;
    logic                 fits;

    // incoming remainder is below the divisor, so the shifted value fits DEN_W+1 bits
    always_comb
    begin
        trial    = {in_rem, in_num[SW-1]};
        fits     = trial >= {1'b0, in_den};
        rem_next = fits ? DEN_W'(trial - {1'b0, in_den}) : trial[DEN_W-1:0];
        num_next = {in_num[SW-2:0], 1'b0};
        quo_next = {in_quo[SW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= in_den;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

>>> design/bm25ts_merge.sv
// Output stage: zero-divisor fix-up and merge with the prior score.
`timescale 1ns / 1ps

module bm25ts_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [bm25ts_pkg::SCORE_W-1:0]    in_quo,
    input  bm25ts_pkg::side_t                 in_side,
    input  logic [1:0]                        merge_mode,
    output logic                              done,
    output bm25ts_pkg::result_t               result
);
    localparam int SW = bm25ts_pkg::SCORE_W;

    logic                 done_reg;
    logic [SW-1:0]        score_reg, score_next;
    logic                 last_reg;

    logic [SW-1:0]        term;
    logic [SW:0]          sum;

    always_comb
    begin
        term = in_side.den_zero ? '0 : in_quo;
        sum  = (SW+1)'(term) + (SW+1)'(in_side.prior_score);
        case (merge_mode)
            bm25ts_pkg::MERGE_SUM:
                score_next = sum[SW] ? bm25ts_pkg::SCORE_MAX : sum[SW-1:0];
            bm25ts_pkg::MERGE_MAX:
                score_next = (term > in_side.prior_score) ? term : in_side.prior_score;
            default:
                score_next = term;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        last_reg  <= in_side.block_last;
    end

    assign done                  = done_reg;
    assign result.score          = score_reg;
    assign result.block_last_out = last_reg;

endmodule
